### src/uartbd_pkg.sv
// ============================================================================
// UART baud divisor package
// Widths and fixed-point constants shared by the baud divisor pipeline.
// ============================================================================
package uartbd_pkg;

    // Request and result field widths.
    localparam int unsigned CLK_W   = 28;
    localparam int unsigned BAUD_W  = 24;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned MANT_W  = 12;
    localparam int unsigned FRAC_W  = 4;

    // Numerator 25 * clock needs 33 bits, denominator 4 * baud needs 26 bits.
    localparam int unsigned NUM_W   = 33;
    localparam int unsigned DEN_W   = 26;
    localparam int unsigned NUM_SCALE = 25;

    // Division by 100 of a value below 409600: multiply by ceil(2^26 / 100).
    localparam int unsigned X_W        = 19;
    localparam int unsigned RECIP_W    = 20;
    localparam int unsigned PROD_W     = X_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

    // At or above this scaled divider the mantissa cannot fit in 12 bits.
    localparam logic [NUM_W-1:0] DIV100_LIMIT = 33'd409600;

    // Remainder and rounding of the fraction.
    localparam int unsigned REM_W   = 7;
    localparam logic [6:0]  HUNDRED = 7'd100;
    localparam int unsigned T_W     = 11;
    localparam logic [T_W-1:0] ROUND_HALF = 11'd50;
    // t / 100 for t below 4681 is (t * 1311) >> 17.
    localparam int unsigned FRAC_RECIP_SHIFT = 17;
    localparam logic [T_W-1:0] FRAC_RECIP = 11'd1311;
    localparam int unsigned FQ_W    = 5;
    localparam logic [FQ_W-1:0] SCALE_16 = 5'd16;
    localparam logic [FQ_W-1:0] SCALE_8  = 5'd8;

    localparam logic [WORD_W-1:0] WORD_SAT = 16'hFFFF;

    // Pipeline depth: input stage plus one stage per quotient bit, then
    // reciprocal multiply, remainder, rounding and output stages.
    localparam int unsigned DIV_STAGES = NUM_W + 1;
    localparam int unsigned STG_A   = DIV_STAGES;
    localparam int unsigned STG_B   = DIV_STAGES + 1;
    localparam int unsigned STG_C   = DIV_STAGES + 2;
    localparam int unsigned STG_OUT = DIV_STAGES + 3;
    localparam int unsigned NSTG    = DIV_STAGES + 4;

endpackage

### src/uart_baud_divisor_calc.sv
// ============================================================================
// UART baud divisor calculator
// Fully pipelined fractional baud-rate divisor: 25 * clock / (4 or 2 * baud),
// split into a 12-bit mantissa and a rounded 4-bit or 3-bit fraction.
// ============================================================================
// Usage
//   A request (clock_hz, baud_rate, oversample_by_8) is taken on the input
//   channel when in_valid and in_ready are both high. Each request yields
//   exactly one result (divisor_word, error_flag) on the output channel,
//   handed over when out_valid and out_ready are both high.
//   Each result passes through the stages below into the output register
//   and is held there until the receiver takes it. Throughput: one request
//   per clock cycle while out_ready is high. The pipeline has 38 register
//   stages: an input stage, 33 restoring-division stages that each settle one
//   quotient bit with one 27-bit compare and subtract, a reciprocal multiply
//   for the division by 100, a remainder stage, a rounding stage and the
//   output register. Every stage carries its own valid bit.
//   Stall: a stage loads whenever it is empty or the stage after it moves,
//   so empty slots close up while the receiver holds out_ready low, and the
//   input keeps taking requests until every stage is full. Nothing is lost
//   or repeated.
//   Reset: rst_n clears all valid bits at once; in_ready is high as soon
//   as reset is released.
//   A zero baud rate, or a mantissa above 4095 after the fraction carry,
//   gives error_flag high with divisor_word 16'hFFFF.
// ============================================================================
module uart_baud_divisor_calc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [uartbd_pkg::CLK_W-1:0]    clock_hz,
    input  logic [uartbd_pkg::BAUD_W-1:0]   baud_rate,
    input  logic                            oversample_by_8,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [uartbd_pkg::WORD_W-1:0]   divisor_word,
    output logic                            error_flag
);

    localparam int unsigned NSTG  = uartbd_pkg::NSTG;
    localparam int unsigned NDIV  = uartbd_pkg::DIV_STAGES;
    localparam int unsigned NUM_W = uartbd_pkg::NUM_W;
    localparam int unsigned DEN_W = uartbd_pkg::DEN_W;

    // Valid bit of each stage and the load enable of each stage. The last
    // enable entry stands for the receiver.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   load;

    // Division chain. Entry 0 is the input stage; entry j+1 holds the state
    // after quotient bit j. The numerator shifts out at the top of nq while
    // quotient bits shift in at the bottom.
    logic [DEN_W-1:0] div_rem_reg [NDIV];
    logic [NUM_W-1:0] div_nq_reg  [NDIV];
    logic [DEN_W-1:0] div_den_reg [NDIV];
    logic             div_bz_reg  [NDIV];
    logic             div_by8_reg [NDIV];

    logic [DEN_W-1:0] div_rem_next [NDIV];
    logic [NUM_W-1:0] div_nq_next  [NDIV];

    // Post-division stages.
    logic [uartbd_pkg::PROD_W-1:0] a_prod_reg;
    logic [uartbd_pkg::X_W-1:0]    a_x_reg;
    logic                          a_ovf_reg;
    logic                          a_by8_reg;

    logic [uartbd_pkg::MANT_W-1:0] b_mant_reg;
    logic [uartbd_pkg::REM_W-1:0]  b_rem_reg;
    logic                          b_ovf_reg;
    logic                          b_by8_reg;

    logic [uartbd_pkg::MANT_W-1:0] c_mant_reg;
    logic [uartbd_pkg::FQ_W-1:0]   c_fq_reg;
    logic                          c_ovf_reg;
    logic                          c_by8_reg;

    logic [uartbd_pkg::WORD_W-1:0] out_word_reg;
    logic                          out_err_reg;

    // Combinational values between stages.
    logic [NUM_W-1:0]              num_in;
    logic [DEN_W-1:0]              den_in;
    logic [NUM_W-1:0]              quo;
    logic                          a_ovf_next;
    logic [uartbd_pkg::PROD_W-1:0] a_prod_next;
    logic [uartbd_pkg::MANT_W-1:0] b_mant_next;
    logic [18:0]                   b_mant100;
    logic [uartbd_pkg::REM_W-1:0]  b_rem_next;
    logic [uartbd_pkg::T_W-1:0]    c_t;
    logic [21:0]                   c_prod;
    logic [uartbd_pkg::FQ_W-1:0]   c_fq_next;
    logic                          o_carry;
    logic [uartbd_pkg::MANT_W:0]   o_mant;
    logic [uartbd_pkg::FRAC_W-1:0] o_frac;
    logic                          o_err;
    logic [uartbd_pkg::WORD_W-1:0] out_word_next;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        load[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Input stage operands: 25 * clock and 4 * baud (2 * baud by 8).
    assign num_in = NUM_W'(clock_hz) * NUM_W'(uartbd_pkg::NUM_SCALE);
    assign den_in = oversample_by_8 ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};

    // One restoring-division step per stage.
    always_comb
    begin
        logic [DEN_W:0] trial;
        for (int j = 0; j < NDIV - 1; j++)
        begin
            trial = {div_rem_reg[j], div_nq_reg[j][NUM_W-1]};
            if (trial >= {1'b0, div_den_reg[j]})
            begin
                div_rem_next[j+1] = DEN_W'(trial - {1'b0, div_den_reg[j]});
                div_nq_next[j+1]  = {div_nq_reg[j][NUM_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next[j+1] = trial[DEN_W-1:0];
                div_nq_next[j+1]  = {div_nq_reg[j][NUM_W-2:0], 1'b0};
            end
        end
        div_rem_next[0] = '0;
        div_nq_next[0]  = num_in;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            div_rem_reg[0] <= div_rem_next[0];
            div_nq_reg[0]  <= div_nq_next[0];
            div_den_reg[0] <= den_in;
            div_bz_reg[0]  <= (baud_rate == '0);
            div_by8_reg[0] <= oversample_by_8;
        end
        for (int j = 1; j < NDIV; j++)
        begin
            if (load[j])
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_nq_reg[j]  <= div_nq_next[j];
                div_den_reg[j] <= div_den_reg[j-1];
                div_bz_reg[j]  <= div_bz_reg[j-1];
                div_by8_reg[j] <= div_by8_reg[j-1];
            end
        end
    end

    // Stage A: range check of the scaled divider and reciprocal multiply
    // for the division by 100.
    assign quo         = div_nq_reg[NDIV-1];
    assign a_ovf_next  = div_bz_reg[NDIV-1] || (quo >= uartbd_pkg::DIV100_LIMIT);
    assign a_prod_next = uartbd_pkg::PROD_W'(quo[uartbd_pkg::X_W-1:0])
                       * uartbd_pkg::PROD_W'(uartbd_pkg::RECIP_100);

    // Stage B: mantissa and remainder.
    assign b_mant_next = a_prod_reg[uartbd_pkg::RECIP_SHIFT +: uartbd_pkg::MANT_W];
    assign b_mant100   = 19'(b_mant_next) * 19'(uartbd_pkg::HUNDRED);
    assign b_rem_next  = uartbd_pkg::REM_W'(a_x_reg - b_mant100);

    // Stage C: fraction rounded to sixteenths or eighths.
    always_comb
    begin
        if (b_by8_reg)
        begin
            c_t = {1'b0, b_rem_reg, 3'b000} + uartbd_pkg::ROUND_HALF;
        end
        else
        begin
            c_t = {b_rem_reg, 4'b0000} + uartbd_pkg::ROUND_HALF;
        end
    end
    assign c_prod    = 22'(c_t) * 22'(uartbd_pkg::FRAC_RECIP);
    assign c_fq_next = c_prod[uartbd_pkg::FRAC_RECIP_SHIFT +: uartbd_pkg::FQ_W];

    // Output stage: a fraction that rounded up to the full scale carries
    // into the mantissa, then the range is checked again.
    assign o_carry = c_by8_reg ? (c_fq_reg >= uartbd_pkg::SCALE_8)
                               : (c_fq_reg >= uartbd_pkg::SCALE_16);
    assign o_mant  = {1'b0, c_mant_reg} + {{uartbd_pkg::MANT_W{1'b0}}, o_carry};
    assign o_frac  = o_carry ? '0 : c_fq_reg[uartbd_pkg::FRAC_W-1:0];
    assign o_err   = c_ovf_reg || o_mant[uartbd_pkg::MANT_W];
    assign out_word_next = o_err ? uartbd_pkg::WORD_SAT
                                 : {o_mant[uartbd_pkg::MANT_W-1:0], o_frac};

    always_ff @(posedge clk)
    begin
        if (load[uartbd_pkg::STG_A])
        begin
            a_prod_reg <= a_prod_next;
            a_x_reg    <= quo[uartbd_pkg::X_W-1:0];
            a_ovf_reg  <= a_ovf_next;
            a_by8_reg  <= div_by8_reg[NDIV-1];
        end
        if (load[uartbd_pkg::STG_B])
        begin
            b_mant_reg <= b_mant_next;
            b_rem_reg  <= b_rem_next;
            b_ovf_reg  <= a_ovf_reg;
            b_by8_reg  <= a_by8_reg;
        end
        if (load[uartbd_pkg::STG_C])
        begin
            c_mant_reg <= b_mant_reg;
            c_fq_reg   <= c_fq_next;
            c_ovf_reg  <= b_ovf_reg;
            c_by8_reg  <= b_by8_reg;
        end
        if (load[uartbd_pkg::STG_OUT])
        begin
            out_word_reg <= out_word_next;
            out_err_reg  <= o_err;
        end
    end

    assign out_valid    = valid_reg[uartbd_pkg::STG_OUT];
    assign divisor_word = out_word_reg;
    assign error_flag   = out_err_reg;

endmodule
